// File: rtl/clt_pkg.sv
// shared types, character codes and scan phase codes for the tokenizer
// no dependencies
package clt_pkg;

    localparam int DEF_MAX_TOKENS  = 16;
    localparam int DEF_LINE_LENGTH = 256;

    localparam logic [2:0] PH_IDLE   = 3'd0;
    localparam logic [2:0] PH_SIGN   = 3'd1;
    localparam logic [2:0] PH_ZERO   = 3'd2;
    localparam logic [2:0] PH_PREFIX = 3'd3;
    localparam logic [2:0] PH_DIGITS = 3'd4;
    localparam logic [2:0] PH_ALPHA  = 3'd5;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UF    = 8'h46;
    localparam logic [7:0] CH_UX    = 8'h58;
    localparam logic [7:0] CH_UZ    = 8'h5A;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LF    = 8'h66;
    localparam logic [7:0] CH_LX    = 8'h78;
    localparam logic [7:0] CH_LZ    = 8'h7A;

    typedef struct packed {
        logic [2:0]  phase;
        logic        negative;
        logic        hex;
        logic [31:0] acc;
        logic [7:0]  start;
        logic [7:0]  pos;
        logic        overflow;
    } scan_state_t;

    typedef struct packed {
        logic        token_valid;
        logic        token_kind;
        logic [31:0] token_value;
        logic [7:0]  token_start;
        logic [3:0]  token_number;
        logic        line_done;
        logic [4:0]  token_total;
        logic        tokens_dropped;
    } result_t;

    function automatic logic is_dec(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic is_hex_letter(input logic [7:0] c);
        return ((c >= CH_LA) && (c <= CH_LF)) || ((c >= CH_UA) && (c <= CH_UF));
    endfunction

    function automatic logic is_sep(input logic [7:0] c);
        return !((c == CH_PLUS) || (c == CH_MINUS) || is_dec(c)
                 || ((c >= CH_LA) && (c <= CH_LZ)) || ((c >= CH_UA) && (c <= CH_UZ)));
    endfunction

    // value of a decimal digit or a hex letter
    function automatic logic [3:0] digit_val(input logic [7:0] c);
        if (is_dec(c))
        begin
            return c[3:0];
        end
        return 4'(c[3:0] + 4'd9);
    endfunction

endpackage

// File: rtl/clt_scan.sv
// next-state and result logic for one character of the line
// depends on clt_pkg
module clt_scan #(
    parameter int MAX_TOKENS  = clt_pkg::DEF_MAX_TOKENS,
    parameter int LINE_LENGTH = clt_pkg::DEF_LINE_LENGTH
) (
    input  logic [7:0]                         char_code,
    input  logic                               last_char,
    input  clt_pkg::scan_state_t               state_cur,
    input  logic [$clog2(MAX_TOKENS+1)-1:0]    count_cur,
    output clt_pkg::scan_state_t               state_nxt,
    output logic [$clog2(MAX_TOKENS+1)-1:0]    count_nxt,
    output logic                               has_result,
    output clt_pkg::result_t                   result
);
    import clt_pkg::*;

    localparam int CNT_W   = $clog2(MAX_TOKENS + 1);
    localparam int POS_LIM = ((LINE_LENGTH - 1) < 255) ? (LINE_LENGTH - 1) : 255;
    localparam logic [7:0]       POS_MAX = 8'(POS_LIM);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_TOKENS);

    always_comb
    begin
        scan_state_t       s;
        logic [CNT_W-1:0]  cnt;
        logic [CNT_W+4:0]  cnt_ext;
        logic [CNT_W+4:0]  num_ext;
        logic              sep;
        logic              eol;
        logic              dec;
        logic              kind;
        logic [31:0]       d32;

        s   = state_cur;
        cnt = count_cur;
        sep = is_sep(char_code);
        eol = (char_code == CH_NUL) || last_char;
        dec = is_dec(char_code);
        d32 = 32'(digit_val(char_code));
        kind    = 1'b0;
        result  = '0;
        num_ext = '0;

        if (!sep)
        begin
            unique case (s.phase)
                PH_IDLE:
                begin
                    s.start    = s.pos;
                    s.negative = 1'b0;
                    s.hex      = 1'b0;
                    s.acc      = '0;
                    if ((char_code == CH_PLUS) || (char_code == CH_MINUS))
                    begin
                        s.negative = (char_code == CH_MINUS);
                        s.phase    = PH_SIGN;
                    end
                    else if (char_code == CH_ZERO)
                    begin
                        s.phase = PH_ZERO;
                    end
                    else if (dec)
                    begin
                        s.acc   = d32;
                        s.phase = PH_DIGITS;
                    end
                    else
                    begin
                        s.phase = PH_ALPHA;
                    end
                end
                PH_SIGN:
                begin
                    if (char_code == CH_ZERO)
                    begin
                        s.phase = PH_ZERO;
                    end
                    else if (dec)
                    begin
                        s.acc   = d32;
                        s.phase = PH_DIGITS;
                    end
                    else
                    begin
                        s.phase = PH_ALPHA;
                    end
                end
                PH_ZERO:
                begin
                    if ((char_code == CH_LX) || (char_code == CH_UX))
                    begin
                        s.hex   = 1'b1;
                        s.phase = PH_PREFIX;
                    end
                    else if (dec)
                    begin
                        s.acc   = d32;
                        s.phase = PH_DIGITS;
                    end
                    else
                    begin
                        s.phase = PH_ALPHA;
                    end
                end
                PH_PREFIX:
                begin
                    if (dec || is_hex_letter(char_code))
                    begin
                        s.acc   = d32;
                        s.phase = PH_DIGITS;
                    end
                    else
                    begin
                        s.phase = PH_ALPHA;
                    end
                end
                PH_DIGITS:
                begin
                    if (s.hex && (dec || is_hex_letter(char_code)))
                    begin
                        s.acc = {s.acc[27:0], 4'b0} + d32;
                    end
                    else if (!s.hex && dec)
                    begin
                        s.acc = {s.acc[28:0], 3'b0} + {s.acc[30:0], 1'b0} + d32;
                    end
                    else
                    begin
                        s.phase = PH_ALPHA;
                    end
                end
                PH_ALPHA:
                begin
                    s.phase = PH_ALPHA;
                end
                default:
                begin
                    s.phase = PH_IDLE;
                end
            endcase
        end
        else if ((s.phase != PH_SIGN) && (s.phase != PH_ZERO) && (s.phase != PH_PREFIX)
                 && (s.phase != PH_DIGITS) && (s.phase != PH_ALPHA))
        begin
            s.phase = PH_IDLE;
        end

        // token end
        if ((sep || eol) && (s.phase != PH_IDLE))
        begin
            kind = (s.phase != PH_ALPHA);
            if (cnt < CNT_MAX)
            begin
                num_ext             = {5'b0, cnt};
                result.token_valid  = 1'b1;
                result.token_kind   = kind;
                result.token_value  = kind ? (s.negative ? (~s.acc + 32'd1) : s.acc) : 32'd0;
                result.token_start  = s.start;
                result.token_number = num_ext[3:0];
                cnt                 = cnt + CNT_W'(1);
            end
            else
            begin
                s.overflow = 1'b1;
            end
            s.phase = PH_IDLE;
        end

        cnt_ext               = {5'b0, cnt};
        result.line_done      = eol;
        result.token_total    = eol ? cnt_ext[4:0] : 5'd0;
        result.tokens_dropped = s.overflow;
        has_result            = result.token_valid || eol;

        if (eol)
        begin
            s   = '0;
            cnt = '0;
        end
        else if (s.pos < POS_MAX)
        begin
            s.pos = s.pos + 8'd1;
        end

        state_nxt = s;
        count_nxt = cnt;
    end

endmodule

// File: rtl/command_line_number_tokenizer.sv
// Splits a command line, one character per beat, into alpha and numeric tokens
// (signed decimal or 0x hex, wrapped to 32 bits) and reports each token as it
// ends. A character is taken on every clock cycle while char_stall is low; its
// result, if any, computed by the scanner's single decode and multiply-add step,
// is registered in the first output entry, or in the second while that is held.
// A two-entry output buffer keeps input flowing while a result waits; char_stall
// rises only when both entries are full. Depends on clt_pkg and clt_scan.
module command_line_number_tokenizer #(
    parameter int MAX_TOKENS  = clt_pkg::DEF_MAX_TOKENS,
    parameter int LINE_LENGTH = clt_pkg::DEF_LINE_LENGTH
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               char_valid,
    output logic               char_stall,
    input  logic [7:0]         char_code,
    input  logic               last_char,
    output logic               result_valid,
    input  logic               result_stall,
    output logic               token_valid,
    output logic               token_kind,
    output logic signed [31:0] token_value,
    output logic [7:0]         token_start,
    output logic [3:0]         token_number,
    output logic               line_done,
    output logic [4:0]         token_total,
    output logic               tokens_dropped
);
    import clt_pkg::*;

    localparam int CNT_W = $clog2(MAX_TOKENS + 1);

    scan_state_t      state_reg;
    scan_state_t      state_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             has_result;
    result_t          scan_res;
    result_t          out_reg;
    result_t          skid_reg;
    logic             out_valid_reg;
    logic             skid_valid_reg;
    logic             accept;
    logic             out_take;

    clt_scan #(
        .MAX_TOKENS  (MAX_TOKENS),
        .LINE_LENGTH (LINE_LENGTH)
    ) u_scan (
        .char_code  (char_code),
        .last_char  (last_char),
        .state_cur  (state_reg),
        .count_cur  (count_reg),
        .state_nxt  (state_next),
        .count_nxt  (count_next),
        .has_result (has_result),
        .result     (scan_res)
    );

    assign char_stall = skid_valid_reg;
    assign accept     = char_valid && !skid_valid_reg;
    assign out_take   = out_valid_reg && !result_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
            count_reg <= '0;
        end
        else if (accept)
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_take)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (accept && has_result)
        begin
            if (out_valid_reg && !out_take)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                out_valid_reg <= 1'b1;
            end
        end
        else if (out_take)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_take)
            begin
                out_reg <= skid_reg;
            end
        end
        else if (accept && has_result)
        begin
            if (out_valid_reg && !out_take)
            begin
                skid_reg <= scan_res;
            end
            else
            begin
                out_reg <= scan_res;
            end
        end
    end

    assign result_valid   = out_valid_reg;
    assign token_valid    = out_reg.token_valid;
    assign token_kind     = out_reg.token_kind;
    assign token_value    = out_reg.token_value;
    assign token_start    = out_reg.token_start;
    assign token_number   = out_reg.token_number;
    assign line_done      = out_reg.line_done;
    assign token_total    = out_reg.token_total;
    assign tokens_dropped = out_reg.tokens_dropped;

endmodule

// File: rtl/clt_check.sv
// port-level checks for the tokenizer, bound to the top level
// depends on command_line_number_tokenizer
module clt_check (
    input logic               clk,
    input logic               rst_n,
    input logic               result_valid,
    input logic               result_stall,
    input logic               token_valid,
    input logic               token_kind,
    input logic signed [31:0] token_value,
    input logic [7:0]         token_start,
    input logic [3:0]         token_number,
    input logic               line_done,
    input logic [4:0]         token_total,
    input logic               tokens_dropped
);

    // a beat carries a token, a line end, or both
    a_result_reason: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (token_valid || line_done))
        else $error("result beat with neither token nor line end");

    a_total_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !line_done) |-> (token_total == 5'd0))
        else $error("token total outside line end");

    a_alpha_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && token_valid && !token_kind) |-> (token_value == 32'sd0))
        else $error("alpha token with non-zero value");

    a_bare_end_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !token_valid) |->
            (!token_kind && (token_value == 32'sd0) && (token_start == 8'd0)
             && (token_number == 4'd0)))
        else $error("line end without token carries token fields");

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_stall) |=>
            (result_valid && $stable(token_value) && $stable(token_number)
             && $stable(line_done) && $stable(tokens_dropped)))
        else $error("stalled result beat changed");

endmodule

bind command_line_number_tokenizer clt_check u_clt_check (.*);

// File: tb/token_checker.sv
`timescale 1ns / 1ps
// watches both channels of the tokenizer, predicts each token report from the
// accepted characters and compares every result beat field by field
// depends on clt_pkg
module token_checker #(
    parameter int MAX_TOKENS  = clt_pkg::DEF_MAX_TOKENS,
    parameter int LINE_LENGTH = clt_pkg::DEF_LINE_LENGTH
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        char_valid,
    input  logic        char_stall,
    input  logic [7:0]  char_code,
    input  logic        last_char,
    input  logic        result_valid,
    input  logic        result_stall,
    input  logic        token_valid,
    input  logic        token_kind,
    input  logic [31:0] token_value,
    input  logic [7:0]  token_start,
    input  logic [3:0]  token_number,
    input  logic        line_done,
    input  logic [4:0]  token_total,
    input  logic        tokens_dropped,
    output int          mismatches,
    output int          outstanding
);
    import clt_pkg::*;

    localparam int POS_LIMIT = (LINE_LENGTH - 1 < 255) ? LINE_LENGTH - 1 : 255;

    logic [2:0]  phase;
    logic        negative;
    logic        hex_digits;
    logic [31:0] acc;
    int          start_pos;
    int          pos;
    int          token_count;
    logic        dropped;
    result_t     pending_tokens[$];
    result_t     oldest;

    function automatic logic separator_char(input logic [7:0] c);
        if (c == CH_PLUS || c == CH_MINUS)
        begin
            return 1'b0;
        end
        if ((c >= CH_ZERO && c <= CH_NINE) || (c >= CH_LA && c <= CH_LZ)
            || (c >= CH_UA && c <= CH_UZ))
        begin
            return 1'b0;
        end
        return 1'b1;
    endfunction

    // -1 when not a digit of the base
    function automatic int digit_value(input logic [7:0] c, input logic hex);
        if (c >= CH_ZERO && c <= CH_NINE)
        begin
            return int'(c - CH_ZERO);
        end
        if (hex && c >= CH_LA && c <= CH_LF)
        begin
            return int'(c - CH_LA) + 10;
        end
        if (hex && c >= CH_UA && c <= CH_UF)
        begin
            return int'(c - CH_UA) + 10;
        end
        return -1;
    endfunction

    task automatic clear_line();
        phase       = PH_IDLE;
        negative    = 1'b0;
        hex_digits  = 1'b0;
        acc         = '0;
        start_pos   = 0;
        pos         = 0;
        token_count = 0;
        dropped     = 1'b0;
    endtask

    task automatic scan_char(input logic [7:0] c, input logic last);
        logic    eol;
        logic    sep;
        logic    reported;
        int      d;
        result_t r;
        eol      = (c == CH_NUL) || last;
        sep      = separator_char(c);
        reported = 1'b0;
        r        = '0;
        if (!sep)
        begin
            d = digit_value(c, 1'b0);
            case (phase)
                PH_IDLE:
                begin
                    start_pos  = pos;
                    negative   = 1'b0;
                    hex_digits = 1'b0;
                    acc        = '0;
                    if (c == CH_PLUS || c == CH_MINUS)
                    begin
                        negative = (c == CH_MINUS);
                        phase    = PH_SIGN;
                    end
                    else if (c == CH_ZERO)
                    begin
                        phase = PH_ZERO;
                    end
                    else if (d >= 0)
                    begin
                        acc   = 32'(d);
                        phase = PH_DIGITS;
                    end
                    else
                    begin
                        phase = PH_ALPHA;
                    end
                end
                PH_SIGN:
                begin
                    if (c == CH_ZERO)
                    begin
                        phase = PH_ZERO;
                    end
                    else if (d >= 0)
                    begin
                        acc   = 32'(d);
                        phase = PH_DIGITS;
                    end
                    else
                    begin
                        phase = PH_ALPHA;
                    end
                end
                PH_ZERO:
                begin
                    if (c == CH_LX || c == CH_UX)
                    begin
                        hex_digits = 1'b1;
                        phase      = PH_PREFIX;
                    end
                    else if (d >= 0)
                    begin
                        acc   = 32'(d);
                        phase = PH_DIGITS;
                    end
                    else
                    begin
                        phase = PH_ALPHA;
                    end
                end
                PH_PREFIX:
                begin
                    d = digit_value(c, 1'b1);
                    if (d >= 0)
                    begin
                        acc   = 32'(d);
                        phase = PH_DIGITS;
                    end
                    else
                    begin
                        phase = PH_ALPHA;
                    end
                end
                PH_DIGITS:
                begin
                    d = digit_value(c, hex_digits);
                    if (d >= 0)
                    begin
                        acc = acc * (hex_digits ? 32'd16 : 32'd10) + 32'(d);
                    end
                    else
                    begin
                        phase = PH_ALPHA;
                    end
                end
                default:
                begin
                end
            endcase
        end

        if ((sep || eol) && phase != PH_IDLE)
        begin
            if (token_count < MAX_TOKENS)
            begin
                reported       = 1'b1;
                r.token_valid  = 1'b1;
                r.token_kind   = (phase != PH_ALPHA);
                r.token_value  = (phase == PH_ALPHA) ? 32'd0
                               : (negative ? 32'd0 - acc : acc);
                r.token_start  = start_pos[7:0];
                r.token_number = token_count[3:0];
                token_count++;
            end
            else
            begin
                dropped = 1'b1;
            end
            phase = PH_IDLE;
        end

        if (reported || eol)
        begin
            r.line_done      = eol;
            r.token_total    = eol ? token_count[4:0] : 5'd0;
            r.tokens_dropped = dropped;
            pending_tokens.push_back(r);
        end

        if (eol)
        begin
            clear_line();
        end
        else if (pos < POS_LIMIT)
        begin
            pos++;
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_line();
            pending_tokens.delete();
            mismatches = 0;
        end
        else
        begin
            if (char_valid && !char_stall)
            begin
                scan_char(char_code, last_char);
            end
            if (result_valid && !result_stall)
            begin
                if (pending_tokens.size() == 0)
                begin
                    $error("result beat with no token report outstanding");
                    mismatches++;
                end
                else
                begin
                    oldest = pending_tokens.pop_front();
                    check_field("token_valid", oldest.token_valid, token_valid);
                    check_field("token_kind", oldest.token_kind, token_kind);
                    check_field("token_value", oldest.token_value, token_value);
                    check_field("token_start", oldest.token_start, token_start);
                    check_field("token_number", oldest.token_number, token_number);
                    check_field("line_done", oldest.line_done, line_done);
                    check_field("token_total", oldest.token_total, token_total);
                    check_field("tokens_dropped", oldest.tokens_dropped, tokens_dropped);
                end
            end
        end
        outstanding = pending_tokens.size();
    end

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
// top of the tokenizer bench: clock, reset, command line stimulus and result
// back-pressure; depends on clt_pkg, token_checker and the tokenizer rtl
module testbench;
    import clt_pkg::*;

    localparam int CHAR_ITEMS = 1850;

    logic        clk;
    logic        rst_n;
    logic        char_valid;
    logic        char_stall;
    logic [7:0]  char_code;
    logic        last_char;
    logic        result_valid;
    logic        result_stall;
    logic        token_valid;
    logic        token_kind;
    logic signed [31:0] token_value;
    logic [7:0]  token_start;
    logic [3:0]  token_number;
    logic        line_done;
    logic [4:0]  token_total;
    logic        tokens_dropped;

    int          fail_count;
    int          pending;
    int          chars_sent;
    int          line_count;
    logic        calm;
    logic        line_end_flag;
    logic [7:0]  line_bytes[$];

    command_line_number_tokenizer dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .char_valid     (char_valid),
        .char_stall     (char_stall),
        .char_code      (char_code),
        .last_char      (last_char),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .token_valid    (token_valid),
        .token_kind     (token_kind),
        .token_value    (token_value),
        .token_start    (token_start),
        .token_number   (token_number),
        .line_done      (line_done),
        .token_total    (token_total),
        .tokens_dropped (tokens_dropped)
    );

    token_checker u_token_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .char_valid     (char_valid),
        .char_stall     (char_stall),
        .char_code      (char_code),
        .last_char      (last_char),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .token_valid    (token_valid),
        .token_kind     (token_kind),
        .token_value    (token_value),
        .token_start    (token_start),
        .token_number   (token_number),
        .line_done      (line_done),
        .token_total    (token_total),
        .tokens_dropped (tokens_dropped),
        .mismatches     (fail_count),
        .outstanding    (pending)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    initial
    begin
        #5ms;
        $display("simulation failed");
        $finish;
    end

    // mostly short gaps, now and then a long one
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
        begin
            return 0;
        end
        if (r < 93)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    initial
    begin : result_backpressure
        int n;
        result_stall = 1'b0;
        @(negedge clk);
        forever
        begin
            n = calm ? 0 : gap_len();
            result_stall <= (n > 0);
            repeat ((n > 0) ? n : 1) @(negedge clk);
        end
    end

    function automatic logic [7:0] letter();
        if ($urandom_range(0, 1))
        begin
            return CH_LA + 8'($urandom_range(0, 25));
        end
        return CH_UA + 8'($urandom_range(0, 25));
    endfunction

    function automatic logic [7:0] hex_digit();
        case ($urandom_range(0, 2))
            0:       return CH_ZERO + 8'($urandom_range(0, 9));
            1:       return CH_LA + 8'($urandom_range(0, 5));
            default: return CH_UA + 8'($urandom_range(0, 5));
        endcase
    endfunction

    function automatic logic [7:0] token_char();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6)
        begin
            return letter();
        end
        if (r < 8)
        begin
            return CH_ZERO + 8'($urandom_range(0, 9));
        end
        return (r == 8) ? CH_PLUS : CH_MINUS;
    endfunction

    function automatic logic [7:0] separator_byte();
        case ($urandom_range(0, 5))
            0:       return 8'h20;
            1:       return 8'($urandom_range(1, 8'h2A));
            2:       return ($urandom_range(0, 2) == 0) ? 8'h2C
                            : 8'($urandom_range(8'h2E, 8'h2F));
            3:       return 8'($urandom_range(8'h3A, 8'h40));
            4:       return 8'($urandom_range(8'h5B, 8'h60));
            default: return 8'($urandom_range(8'h7B, 8'hFF));
        endcase
    endfunction

    task automatic send_char(input logic [7:0] c, input logic last);
        int n;
        char_valid <= 1'b1;
        char_code  <= c;
        last_char  <= last;
        @(posedge clk);
        while (char_stall)
        begin
            @(posedge clk);
        end
        chars_sent++;
        @(negedge clk);
        n = calm ? 0 : gap_len();
        if (n > 0)
        begin
            char_valid <= 1'b0;
            repeat (n) @(negedge clk);
        end
    endtask

    task automatic send_string(input string s, input logic last);
        for (int i = 0; i < s.len(); i++)
        begin
            send_char(s[i], last && (i == s.len() - 1));
        end
    endtask

    task automatic add_separators(input int n);
        repeat (n) line_bytes.push_back(separator_byte());
    endtask

    task automatic add_number();
        int   sign_sel;
        int   ndig;
        logic hexed;
        sign_sel = $urandom_range(0, 2);
        hexed    = 1'($urandom_range(0, 1));
        ndig     = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 14)
                                               : $urandom_range(0, 4);
        if (sign_sel == 1)
        begin
            line_bytes.push_back(CH_PLUS);
        end
        else if (sign_sel == 2)
        begin
            line_bytes.push_back(CH_MINUS);
        end
        if (hexed)
        begin
            line_bytes.push_back(CH_ZERO);
            line_bytes.push_back($urandom_range(0, 1) ? CH_LX : CH_UX);
        end
        else if (sign_sel == 0 && ndig == 0)
        begin
            ndig = 1;
        end
        repeat (ndig)
        begin
            line_bytes.push_back(hexed ? hex_digit() : CH_ZERO + 8'($urandom_range(0, 9)));
        end
    endtask

    // words and malformed numbers
    task automatic add_word();
        if ($urandom_range(0, 2) == 0)
        begin
            add_number();
            line_bytes.push_back(($urandom_range(0, 3) == 0) ? CH_LX : letter());
        end
        else
        begin
            line_bytes.push_back(letter());
        end
        repeat ($urandom_range(0, 6)) line_bytes.push_back(token_char());
    endtask

    task automatic build_line();
        int r;
        int ntok;
        line_bytes.delete();
        r = $urandom_range(0, 49);
        if (r == 0)
        begin
            // push token starts past the saturating position counter
            add_separators($urandom_range(250, 300));
            ntok = 3;
        end
        else if (r < 7)
        begin
            ntok = $urandom_range(15, 22);
        end
        else
        begin
            ntok = $urandom_range(0, 5);
        end
        if ($urandom_range(0, 3) == 0)
        begin
            add_separators(1);
        end
        for (int i = 0; i < ntok; i++)
        begin
            if ($urandom_range(0, 1))
            begin
                add_number();
            end
            else
            begin
                add_word();
            end
            if (i < ntok - 1)
            begin
                add_separators($urandom_range(1, 2));
            end
        end
        case ($urandom_range(0, 3))
            0:
            begin
                line_bytes.push_back(CH_NUL);
                line_end_flag = 1'($urandom_range(0, 1));
            end
            1:
            begin
                if (line_bytes.size() == 0)
                begin
                    line_bytes.push_back(CH_NUL);
                end
                line_end_flag = 1'b1;
            end
            2:
            begin
                add_separators(1);
                line_end_flag = 1'b1;
            end
            default:
            begin
                line_bytes.push_back(CH_NUL);
                line_end_flag = 1'b0;
            end
        endcase
    endtask

    task automatic send_line();
        for (int i = 0; i < line_bytes.size(); i++)
        begin
            send_char(line_bytes[i], (i == line_bytes.size() - 1) ? line_end_flag : 1'b0);
        end
    endtask

    task automatic send_noise();
        repeat ($urandom_range(1, 30))
        begin
            send_char(8'($urandom_range(0, 255)), $urandom_range(0, 15) == 0);
        end
    endtask

    initial
    begin
        rst_n      = 1'b0;
        char_valid = 1'b0;
        char_code  = '0;
        last_char  = 1'b0;
        calm       = 1'b0;
        chars_sent = 0;
        line_count = 0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // lone sign, bare prefix, largest hex, alpha, line endings
        send_string("- 0X 0xffffffff", 1'b0);
        send_char(CH_NUL, 1'b1);
        send_string("a9,-12", 1'b1);
        send_char(CH_NUL, 1'b0);
        send_char(8'hFF, 1'b1);

        while (chars_sent < CHAR_ITEMS)
        begin
            calm = ($urandom_range(0, 5) == 0);
            if (line_count == 2 || $urandom_range(0, 39) == 0)
            begin
                char_valid <= 1'b0;
                wait (pending == 0);
                @(negedge clk);
            end
            if ($urandom_range(0, 7) == 0)
            begin
                send_noise();
            end
            else
            begin
                build_line();
                send_line();
            end
            line_count++;
        end

        char_valid <= 1'b0;
        wait (pending == 0);
        repeat (10) @(posedge clk);
        if (fail_count == 0 && pending == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
